@@ rtl/ffpa_pkg.sv @@
// Shared types, constants and state codes of the first-fit page allocator.
`default_nettype none
package ffpa_pkg;

   // Field widths of the request and response items.
   localparam int CMD_W   = 1;
   localparam int SIZE_W  = 32;
   localparam int START_W = 12;
   localparam int ADDR_W  = 48;
   localparam int FREE_W  = 13;

   // Use map organization: one memory word holds the bits of 64 pages.
   localparam int WORD_W = 64;
   localparam int LANE_W = 6;

   // Defaults of the top-level parameters.
   localparam int PAGE_COUNT_DEF     = 4096;
   localparam int PAGE_SIZE_LOG2_DEF = 12;

   // Register port: 64-bit data, registers at byte address 8*i.
   localparam int CSR_DW = 64;
   localparam int CSR_AW = 4;
   localparam logic [0:0] REG_DATA_BASE = 1'b0;

   // Command codes.
   localparam logic [CMD_W-1:0] CMD_ALLOC = 1'b0;
   localparam logic [CMD_W-1:0] CMD_CLEAR = 1'b1;

   typedef struct packed {
      logic [CMD_W-1:0]  cmd;
      logic [SIZE_W-1:0] size_bytes;
   } req_type;

   typedef struct packed {
      logic               granted;
      logic [START_W-1:0] start_page;
      logic [ADDR_W-1:0]  address;
      logic [FREE_W-1:0]  free_pages;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_CALC,
      ST_MARK_RD,
      ST_MARK_WR,
      ST_ADDR,
      ST_FIN
   } state_type;

endpackage
`default_nettype wire

@@ rtl/ffpa_ram.sv @@
// Generic single-clock RAM with one write port and one registered read port.
`default_nettype none
module ffpa_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  wire logic                                  clock,
   input  wire logic                                  wr_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                      wr_data,
   input  wire logic                                  rd_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule
`default_nettype wire

@@ rtl/ffpa_scan.sv @@
// Evaluates one use map word of 64 pages against the run carried in from earlier words.
`default_nettype none
module ffpa_scan
   import ffpa_pkg::*;
#(
   parameter int RUN_W = 13
) (
   input  wire logic [WORD_W-1:0] word_i,
   input  wire logic [RUN_W-1:0]  run_i,
   input  wire logic [RUN_W-1:0]  pages_i,
   output logic                   hit_o,
   output logic [LANE_W-1:0]      lane_o,
   output logic [RUN_W-1:0]       run_next_o
);

   localparam int TOT_W = ((RUN_W > LANE_W + 1) ? RUN_W : LANE_W + 1) + 1;

   // lv[s][j] is one plus the index of the last used page at or below lane j,
   // looking back 2^s lanes; zero means no used page was found.
   logic [LANE_W:0]     lv [LANE_W+1][WORD_W];
   logic [WORD_W-1:0]   hit_vec;
   logic [TOT_W-1:0]    total;
   logic [LANE_W:0]     last_top;

   // Prefix scan for the last used page, six levels of muxes.
   always_comb begin
      for (int j = 0; j < WORD_W; j++) begin
         lv[0][j] = word_i[j] ? (LANE_W+1)'(j + 1) : '0;
      end
      for (int s = 0; s < LANE_W; s++) begin
         for (int j = 0; j < WORD_W; j++) begin
            if (j >= (1 << s) && lv[s][j] == '0) begin
               lv[s+1][j] = lv[s][j - (1 << s)];
            end else begin
               lv[s+1][j] = lv[s][j];
            end
         end
      end
   end

   // A lane hits when it is free and the free run ending there is long enough.
   always_comb begin
      hit_vec = '0;
      total   = '0;
      for (int j = 0; j < WORD_W; j++) begin
         if (lv[LANE_W][j] == '0) begin
            total = TOT_W'(run_i) + TOT_W'(j + 1);
         end else begin
            total = TOT_W'(j + 1) - TOT_W'(lv[LANE_W][j]);
         end
         hit_vec[j] = !word_i[j] && (total >= TOT_W'(pages_i));
      end
   end

   // The lowest hitting lane ends the first fitting run.
   always_comb begin
      lane_o = '0;
      for (int j = WORD_W - 1; j >= 0; j--) begin
         if (hit_vec[j]) begin
            lane_o = LANE_W'(j);
         end
      end
   end

   assign hit_o = |hit_vec;

   // Free run carried into the next word.
   assign last_top = lv[LANE_W][WORD_W-1];
   always_comb begin
      if (last_top == '0) begin
         run_next_o = RUN_W'(TOT_W'(run_i) + TOT_W'(WORD_W));
      end else begin
         run_next_o = RUN_W'(TOT_W'(WORD_W) - TOT_W'(last_top));
      end
   end

endmodule
`default_nettype wire

@@ rtl/first_fit_page_allocator.sv @@
// Top level of the first-fit contiguous page allocator.
//
// The allocator keeps one use bit per page in a RAM of 64-bit words and a
// count of free pages. An allocate item rounds size_bytes up to pages of
// 2^PAGE_SIZE_LOG2 bytes, scans the map from page 0 one word per cycle for
// the first run of free pages that fits inside the map, marks it used with a
// read-modify-write of every word it covers and returns the start page, the
// byte address data_base + start * page size (mod 2^48) and the free count.
// A size of zero returns the first free page and marks nothing. A clear item
// writes every map word to zero. A request larger than the map is refused.
// After reset the same clearing pass runs before the first item is taken;
// register writes are taken at any time. A finished result waits in the
// output register while the next item is accepted.
`default_nettype none
module first_fit_page_allocator
   import ffpa_pkg::*;
#(
   parameter int PAGE_COUNT     = PAGE_COUNT_DEF,
   parameter int PAGE_SIZE_LOG2 = PAGE_SIZE_LOG2_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   // Request channel.
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire req_type           req_data,
   // Response channel.
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output rsp_type                rsp_data,
   // Register port.
   input  wire logic              csr_psel,
   input  wire logic              csr_penable,
   input  wire logic              csr_pwrite,
   input  wire logic [CSR_AW-1:0] csr_paddr,
   input  wire logic [CSR_DW-1:0] csr_pwdata,
   output logic      [CSR_DW-1:0] csr_prdata,
   output logic                   csr_pready
);

   localparam int WORDS     = (PAGE_COUNT + WORD_W - 1) / WORD_W;
   localparam int WORD_AW   = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int GP_W      = WORD_AW + LANE_W;
   localparam int RUN_W     = $clog2(PAGE_COUNT + 1);
   localparam int PG_W      = SIZE_W + 1 - PAGE_SIZE_LOG2;
   localparam int CMP_W     = (PG_W > RUN_W) ? PG_W : RUN_W;
   localparam int LAST_VALID = PAGE_COUNT - (WORDS - 1) * WORD_W;
   localparam logic [WORD_W-1:0] PAD_MASK =
      (LAST_VALID == WORD_W) ? '0 : ~((WORD_W'(1) << LAST_VALID) - WORD_W'(1));
   localparam logic [SIZE_W-1:0] LOW_MASK = SIZE_W'((64'd1 << PAGE_SIZE_LOG2) - 64'd1);

   state_type state_ff, state_in;

   logic [ADDR_W-1:0]  data_base_ff;
   logic [RUN_W-1:0]   free_ff;
   logic [RUN_W-1:0]   pages_ff;
   logic [RUN_W-1:0]   run_ff;
   logic               clr_reply_ff;
   logic [WORD_AW-1:0] clr_addr_ff;
   logic [WORD_AW:0]   scan_addr_ff;
   logic               rd_valid_ff;
   logic [WORD_AW-1:0] rd_word_ff;
   logic [GP_W-1:0]    end_ff;
   logic [GP_W-1:0]    start_ff;
   logic [WORD_AW-1:0] mark_word_ff;
   logic               granted_ff;
   logic [ADDR_W-1:0]  addr_ff;
   logic               rsp_valid_ff;
   rsp_type            rsp_data_ff;

   logic               req_fire;
   logic               csr_write;
   logic [PG_W-1:0]    pages_full;
   logic               too_big;
   logic               scan_issue;
   logic               last_word;
   logic [WORD_W-1:0]  scan_word;
   logic               scan_hit;
   logic [LANE_W-1:0]  scan_lane;
   logic [RUN_W-1:0]   scan_run_next;
   logic [RUN_W-1:0]   pages_nz;
   logic [GP_W-1:0]    start_calc;
   logic [LANE_W-1:0]  mark_lo;
   logic [LANE_W-1:0]  mark_hi;
   logic [WORD_W-1:0]  mark_mask;
   logic               mark_last;
   logic               rsp_load;

   logic               ram_wr_en;
   logic [WORD_AW-1:0] ram_wr_addr;
   logic [WORD_W-1:0]  ram_wr_data;
   logic               ram_rd_en;
   logic [WORD_AW-1:0] ram_rd_addr;
   logic [WORD_W-1:0]  ram_rd_data;

   // Register port: always ready, write on the access cycle.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[CSR_AW-1 -: 1] == REG_DATA_BASE) ?
                       CSR_DW'(data_base_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         data_base_ff <= '0;
      end else if (csr_write && csr_paddr[CSR_AW-1 -: 1] == REG_DATA_BASE) begin
         data_base_ff <= csr_pwdata[ADDR_W-1:0];
      end
   end

   // Page count of the request, rounded up, and the check against the map size.
   assign req_fire   = req_valid && req_ready;
   assign pages_full = PG_W'(req_data.size_bytes >> PAGE_SIZE_LOG2) +
                       PG_W'(|(req_data.size_bytes & LOW_MASK));
   assign too_big    = CMP_W'(pages_full) > CMP_W'(PAGE_COUNT);

   // Scan datapath: pad pages beyond the map read as used.
   assign scan_issue = scan_addr_ff < (WORD_AW+1)'(WORDS);
   assign last_word  = rd_word_ff == WORD_AW'(WORDS - 1);
   assign scan_word  = last_word ? (ram_rd_data | PAD_MASK) : ram_rd_data;

   ffpa_scan #(
      .RUN_W (RUN_W)
   ) u_scan (
      .word_i     (scan_word),
      .run_i      (run_ff),
      .pages_i    (pages_ff),
      .hit_o      (scan_hit),
      .lane_o     (scan_lane),
      .run_next_o (scan_run_next)
   );

   // Start of the run; a zero-page request starts at the page it found.
   assign pages_nz   = (pages_ff == '0) ? RUN_W'(1) : pages_ff;
   assign start_calc = GP_W'((GP_W+1)'(end_ff) + (GP_W+1)'(1) - (GP_W+1)'(pages_nz));

   // Bits of the current word that the run covers.
   assign mark_last = mark_word_ff == end_ff[GP_W-1:LANE_W];
   assign mark_lo   = (mark_word_ff == start_ff[GP_W-1:LANE_W]) ?
                      start_ff[LANE_W-1:0] : '0;
   assign mark_hi   = mark_last ? end_ff[LANE_W-1:0] : LANE_W'(WORD_W - 1);
   assign mark_mask = ({WORD_W{1'b1}} << mark_lo) &
                      ({WORD_W{1'b1}} >> (LANE_W'(WORD_W - 1) - mark_hi));

   assign rsp_load = (state_ff == ST_FIN) && (!rsp_valid_ff || rsp_ready);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_addr_ff == WORD_AW'(WORDS - 1)) begin
               state_in = clr_reply_ff ? ST_FIN : ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               if (req_data.cmd == CMD_CLEAR) begin
                  state_in = ST_CLEAR;
               end else if (too_big) begin
                  state_in = ST_FIN;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (rd_valid_ff) begin
               if (scan_hit) begin
                  state_in = ST_CALC;
               end else if (last_word) begin
                  state_in = ST_FIN;
               end
            end
         end
         ST_CALC: begin
            state_in = (pages_ff == '0) ? ST_ADDR : ST_MARK_RD;
         end
         ST_MARK_RD: begin
            state_in = ST_MARK_WR;
         end
         ST_MARK_WR: begin
            state_in = mark_last ? ST_ADDR : ST_MARK_RD;
         end
         ST_ADDR: begin
            state_in = ST_FIN;
         end
         ST_FIN: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // Memory controls and handshake outputs; the sequencer never overlaps a
   // write with a read of the same word, so no forwarding is needed.
   always_comb begin
      req_ready   = 1'b0;
      ram_wr_en   = 1'b0;
      ram_wr_addr = clr_addr_ff;
      ram_wr_data = '0;
      ram_rd_en   = 1'b0;
      ram_rd_addr = scan_addr_ff[WORD_AW-1:0];
      case (state_ff)
         ST_CLEAR: begin
            ram_wr_en = 1'b1;
         end
         ST_IDLE: begin
            req_ready = 1'b1;
         end
         ST_SCAN: begin
            ram_rd_en = scan_issue;
         end
         ST_MARK_RD: begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = mark_word_ff;
         end
         ST_MARK_WR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = mark_word_ff;
            ram_wr_data = ram_rd_data | mark_mask;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_reply_ff <= 1'b0;
         clr_addr_ff  <= '0;
         free_ff      <= RUN_W'(PAGE_COUNT);
         rsp_valid_ff <= 1'b0;
         rd_valid_ff  <= 1'b0;
         scan_addr_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_CLEAR) begin
            clr_addr_ff <= clr_addr_ff + WORD_AW'(1);
            if (clr_addr_ff == WORD_AW'(WORDS - 1)) begin
               clr_addr_ff <= '0;
               free_ff     <= RUN_W'(PAGE_COUNT);
            end
         end
         if (req_fire) begin
            clr_reply_ff <= (req_data.cmd == CMD_CLEAR);
            scan_addr_ff <= '0;
            rd_valid_ff  <= 1'b0;
         end
         if (state_ff == ST_SCAN) begin
            rd_valid_ff <= scan_issue;
            if (scan_issue) begin
               scan_addr_ff <= scan_addr_ff + (WORD_AW+1)'(1);
            end
         end
         if (state_ff == ST_CALC) begin
            free_ff <= free_ff - pages_ff;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         pages_ff   <= RUN_W'(pages_full);
         run_ff     <= '0;
         granted_ff <= 1'b0;
         start_ff   <= '0;
         addr_ff    <= '0;
      end
      if (state_ff == ST_SCAN) begin
         rd_word_ff <= scan_addr_ff[WORD_AW-1:0];
         if (rd_valid_ff) begin
            run_ff <= scan_run_next;
            end_ff <= {rd_word_ff, scan_lane};
         end
      end
      if (state_ff == ST_CALC) begin
         start_ff     <= start_calc;
         mark_word_ff <= start_calc[GP_W-1:LANE_W];
         granted_ff   <= 1'b1;
      end
      if (state_ff == ST_MARK_WR) begin
         mark_word_ff <= mark_word_ff + WORD_AW'(1);
      end
      if (state_ff == ST_ADDR) begin
         addr_ff <= data_base_ff + (ADDR_W'(start_ff) << PAGE_SIZE_LOG2);
      end
      if (rsp_load) begin
         rsp_data_ff.granted    <= granted_ff;
         rsp_data_ff.start_page <= START_W'(start_ff);
         rsp_data_ff.address    <= addr_ff;
         rsp_data_ff.free_pages <= FREE_W'(free_ff);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Use map storage.
   ffpa_ram #(
      .WIDTH (WORD_W),
      .DEPTH (WORDS)
   ) u_map (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // The free count never exceeds the map size.
   a_free_bound: assert property (@(posedge clock) disable iff (reset)
      free_ff <= RUN_W'(PAGE_COUNT))
      else $error("free page count above map size");

   // A granted run never takes more pages than are free.
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CALC) |-> (free_ff >= pages_ff))
      else $error("grant larger than free page count");

   // Marking stays within the words that the run covers.
   a_mark_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MARK_WR) |-> (mark_word_ff <= end_ff[GP_W-1:LANE_W] &&
                                    mark_word_ff >= start_ff[GP_W-1:LANE_W]))
      else $error("mark word outside granted run");

endmodule
`default_nettype wire

@@ tb/sv/tb.sv @@
// Self-checking testbench of the first-fit page allocator with its own page map tracker.
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import ffpa_pkg::*;

   localparam int PAGES        = PAGE_COUNT_DEF;
   localparam int PAGE_LOG2    = PAGE_SIZE_LOG2_DEF;
   localparam int PAGE_BYTES   = 1 << PAGE_LOG2;
   localparam int MAX_REQ_PAGES = (1 << (SIZE_W - PAGE_LOG2)) - 1;
   localparam int PHASES       = 8;
   localparam int PHASE_ITEMS  = 212;
   localparam int DRAIN_CYCLES = 400;
   localparam longint unsigned CYCLE_LIMIT = 2_000_000;
   localparam logic [ADDR_W-1:0] ADDR_MAX = '1;
   localparam logic [CSR_AW-1:0] DATA_BASE_ADDR = CSR_AW'({REG_DATA_BASE, 3'b000});

   // Tracks the use map and free count, and holds the results still to come.
   class page_map_tracker;
      bit [PAGES-1:0]    used_pages;
      int unsigned       free_count;
      logic [ADDR_W-1:0] data_base;
      rsp_type           expected_q[$];
      int unsigned       mismatches;

      function new();
         used_pages = '0;
         free_count = PAGES;
         data_base  = '0;
         mismatches = 0;
      endfunction

      // Work out the result of one command and update the tracked map.
      function rsp_type apply_command(req_type item);
         rsp_type           res;
         longint unsigned   pages;
         int unsigned       run_len;
         int unsigned       first;
         int unsigned       span;
         bit                found;
         res     = '0;
         run_len = 0;
         first   = 0;
         found   = 1'b0;
         if (item.cmd == CMD_CLEAR) begin
            used_pages = '0;
            free_count = PAGES;
         end else begin
            pages = (64'(item.size_bytes) >> PAGE_LOG2) +
                    64'(item.size_bytes[PAGE_LOG2-1:0] != '0);
            // A zero-page request looks for a single free page but marks nothing.
            if (pages <= PAGES) begin
               span = (pages == 0) ? 1 : 32'(pages);
               for (int p = 0; p < PAGES && !found; p++) begin
                  if (used_pages[p]) begin
                     run_len = 0;
                  end else begin
                     run_len++;
                     if (run_len == span) begin
                        found = 1'b1;
                        first = p + 1 - span;
                     end
                  end
               end
            end
            if (found) begin
               for (int p = 0; p < int'(pages); p++) used_pages[first + p] = 1'b1;
               free_count -= 32'(pages);
               res.granted    = 1'b1;
               res.start_page = START_W'(first);
               res.address    = data_base + (ADDR_W'(first) << PAGE_LOG2);
            end
         end
         res.free_pages = FREE_W'(free_count);
         return res;
      endfunction

      function void note_request(req_type item);
         expected_q.push_back(apply_command(item));
      endfunction

      function void check_field(string name, logic [63:0] want, logic [63:0] got);
         if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
         end
      endfunction

      function void check_response(rsp_type got);
         rsp_type want;
         if (expected_q.size() == 0) begin
            $error("result item 0x%0h arrived with no command outstanding", got);
            mismatches++;
            return;
         end
         want = expected_q.pop_front();
         check_field("granted", want.granted, got.granted);
         check_field("start_page", want.start_page, got.start_page);
         check_field("address", want.address, got.address);
         check_field("free_pages", want.free_pages, got.free_pages);
      endfunction
   endclass

   logic              clock       = 1'b0;
   logic              reset       = 1'b1;
   logic              req_valid   = 1'b0;
   logic              req_ready;
   req_type           req_data    = '0;
   logic              rsp_valid;
   logic              rsp_ready   = 1'b0;
   rsp_type           rsp_data;
   logic              csr_psel    = 1'b0;
   logic              csr_penable = 1'b0;
   logic              csr_pwrite  = 1'b0;
   logic [CSR_AW-1:0] csr_paddr   = '0;
   logic [CSR_DW-1:0] csr_pwdata  = '0;
   logic [CSR_DW-1:0] csr_prdata;
   logic              csr_pready;
   bit                steady_flow = 1'b0;
   longint unsigned   cycle_count = 0;
   page_map_tracker   tracker;

   first_fit_page_allocator u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // 8 ns clock.
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Score every item that crosses either channel.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) tracker.check_response(rsp_data);
         if (req_valid && req_ready) tracker.note_request(req_data);
      end
   end

   // Stall the result channel in bursts, with long ready stretches now and then.
   initial begin : rsp_stall
      int unsigned pick, hold;
      @(posedge clock);
      forever begin
         if (steady_flow) begin
            rsp_ready <= 1'b1;
            @(posedge clock);
         end else begin
            pick = $urandom_range(99);
            hold = (pick < 70) ? $urandom_range(2, 1) :
                   (pick < 95) ? $urandom_range(8, 3) : $urandom_range(40, 15);
            rsp_ready <= 1'b0;
            repeat (hold) @(posedge clock);
            pick = $urandom_range(99);
            hold = (pick < 60) ? $urandom_range(4, 1) :
                   (pick < 90) ? $urandom_range(20, 5) : $urandom_range(200, 50);
            rsp_ready <= 1'b1;
            repeat (hold) @(posedge clock);
         end
      end
   end

   // Offer one command item, wait for it to be taken, then maybe leave a gap.
   task automatic send_item(input logic [CMD_W-1:0] op, input logic [SIZE_W-1:0] nbytes);
      int unsigned pick, gap;
      req_data  <= '{cmd: op, size_bytes: nbytes};
      req_valid <= 1'b1;
      do @(posedge clock); while (req_ready !== 1'b1);
      pick = $urandom_range(99);
      gap  = steady_flow ? 0 :
             (pick < 55) ? 0 :
             (pick < 85) ? $urandom_range(3, 1) :
             (pick < 97) ? $urandom_range(12, 4) : $urandom_range(60, 20);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Stop offering items and wait until every expected result has come back.
   // The falling edge lets the monitor note an item taken at the last edge.
   task automatic drain_results();
      req_valid <= 1'b0;
      @(negedge clock);
      while (tracker.expected_q.size() != 0) @(posedge clock);
   endtask

   // One register transfer: setup cycle, access cycle, then the bus goes idle.
   task automatic csr_access(input logic wr, input logic [CSR_DW-1:0] wdata,
                             output logic [CSR_DW-1:0] rdata);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= DATA_BASE_ADDR;
      csr_pwdata  <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      rdata = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // Program the region base, read it back and let the tracker follow.
   task automatic write_base(input logic [ADDR_W-1:0] value);
      logic [CSR_DW-1:0] readback;
      csr_access(1'b1, CSR_DW'(value), readback);
      csr_access(1'b0, '0, readback);
      tracker.check_field("data_base", value, readback[ADDR_W-1:0]);
      tracker.data_base = value;
   endtask

   initial begin : stimulus
      logic [ADDR_W-1:0] base;
      logic [SIZE_W-1:0] nbytes;
      int unsigned       free_left, pick, roll, pages, trim;
      tracker = new();
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed items under the all-ones base, so every address but that of page 0 wraps.
      write_base(ADDR_MAX);
      send_item(CMD_ALLOC, 32'h0000_0000);
      send_item(CMD_ALLOC, 32'h0000_0001);
      send_item(CMD_ALLOC, 32'h0000_1000);
      send_item(CMD_ALLOC, 32'h0000_1001);
      send_item(CMD_ALLOC, 32'h0000_0000);
      send_item(CMD_ALLOC, 32'hFFFF_FFFF);
      send_item(CMD_ALLOC, 32'h0100_1000);
      send_item(CMD_ALLOC, 32'h0100_0000);
      send_item(CMD_CLEAR, 32'hFFFF_FFFF);
      send_item(CMD_ALLOC, 32'h0100_0000);
      send_item(CMD_ALLOC, 32'h0000_0000);
      send_item(CMD_ALLOC, 32'h0000_0001);
      send_item(CMD_CLEAR, 32'h0000_0000);
      send_item(CMD_ALLOC, 32'h00FF_F000);
      send_item(CMD_ALLOC, 32'h0000_2000);
      send_item(CMD_ALLOC, 32'h0000_0FFF);
      send_item(CMD_ALLOC, 32'h0000_0000);
      send_item(CMD_CLEAR, 32'h5A5A_A5A5);
      send_item(CMD_ALLOC, 32'h0000_0FFF);
      send_item(CMD_ALLOC, 32'h8000_0000);
      send_item(CMD_ALLOC, 32'h0000_1001);
      send_item(CMD_ALLOC, 32'h0000_0000);

      // Random phases: each starts from a clear map and fills it toward full.
      for (int ph = 0; ph < PHASES; ph++) begin
         drain_results();
         case (ph % 4)
            0: base = '0;
            1: base = ADDR_W'({$urandom, $urandom});
            2: base = ADDR_MAX - (ADDR_W'($urandom_range(PAGES - 1)) << PAGE_LOG2);
            default: begin
               base = ADDR_W'({$urandom, $urandom});
               base[PAGE_LOG2-1:0] = '0;
            end
         endcase
         write_base(base);
         steady_flow <= (ph == 3);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            free_left = tracker.free_count;
            pick = $urandom_range(99);
            if (n == 0 || pick < 3 || (free_left < 64 && pick < 25)) begin
               send_item(CMD_CLEAR, $urandom);
            end else begin
               // Page count first, then a byte size that rounds up to it, or now and then a random size.
               trim = ($urandom_range(3) == 0) ? 0 : $urandom_range(PAGE_BYTES - 1);
               roll = $urandom_range(99);
               if (roll < 40) begin
                  pages = $urandom_range(8, 1);
               end else if (roll < 65) begin
                  pages = $urandom_range(200, 9);
               end else if (roll < 75) begin
                  // Exactly what is left, one more, or one or two less.
                  pages = free_left + $urandom_range(1);
                  if (pages > 1 && $urandom_range(2) == 0) pages -= 2;
               end else if (roll < 82) begin
                  pages = 0;
               end else if (roll < 88) begin
                  pages = $urandom_range(PAGES, 201);
               end else begin
                  pages = $urandom_range(MAX_REQ_PAGES, PAGES + 1);
               end
               nbytes = (pages == 0) ? '0 : SIZE_W'((64'(pages) << PAGE_LOG2) - trim);
               if (roll >= 94) nbytes = $urandom;
               send_item(CMD_ALLOC, nbytes);
            end
         end
      end

      // Let any late or stray result show up before the verdict.
      drain_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (tracker.mismatches == 0 && tracker.expected_q.size() == 0) begin
         $display("first_fit_page_allocator regression: pass");
      end else begin
         $display("first_fit_page_allocator regression: fail");
      end
      $finish;
   end

   // Give up if the run hangs.
   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("first_fit_page_allocator regression: fail");
      $finish;
   end

endmodule

@@ sim.f @@
rtl/ffpa_pkg.sv
rtl/ffpa_ram.sv
rtl/ffpa_scan.sv
rtl/first_fit_page_allocator.sv
tb/sv/tb.sv
